/* sv/fst_pkg.sv */
// shared types and constants of the flex sensor tone conditioner
`timescale 1ns / 1ps
`default_nettype none
package fst_pkg;

	// field widths
	localparam int LVL_W   = 10;
	localparam int FREQ_W  = 10;
	localparam int THR_W   = 10;
	localparam int PLAY_W  = 16;
	localparam int TIMER_W = 17;
	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 4;

	// serial arithmetic unit
	localparam int SR_W      = 25;
	localparam int ACC_W     = 22;
	localparam int REM_W     = 10;
	localparam int CNT_W     = 5;
	localparam int FRAC_W    = 16;
	localparam int MUL_STEPS = 20;
	localparam int PROD_LOW  = MUL_STEPS - FRAC_W;
	localparam int PROD_W    = ACC_W + PROD_LOW;
	localparam int V_SHIFT   = SR_W - LVL_W;
	localparam int V_W       = 18;
	localparam int VSQ_W     = 20;
	localparam int LIN_W     = 24;
	localparam int SQ_W      = 25;
	localparam int ANGLE_W   = 28;
	localparam int SCALED_W  = 32;

	// level * 3.3 / 1023 in Q16 reduces to (level << 15) / 155
	localparam logic [ACC_W-1:0]   V_DIVISOR  = ACC_W'(155);
	localparam logic [ACC_W-1:0]   COEF_LIN   = ACC_W'(3624141);
	localparam logic [ACC_W-1:0]   COEF_SQ    = ACC_W'(2614886);
	localparam logic [ANGLE_W-1:0] COEF_CONST = ANGLE_W'(4672717);
	localparam logic [SCALED_W-1:0] FREQ_SCALE = SCALED_W'(980 / 90);
	localparam logic [FREQ_W-1:0]  FREQ_MAX   = '1;
	localparam logic [TIMER_W-1:0] TIMER_MAX  = '1;

	// configuration registers
	localparam logic [1:0] REG_NOISE = 2'd0;
	localparam logic [1:0] REG_PIEZO = 2'd1;
	localparam logic [1:0] REG_PLAY  = 2'd2;

	localparam logic [THR_W-1:0]  NOISE_RST = THR_W'(10);
	localparam logic [THR_W-1:0]  PIEZO_RST = THR_W'(150);
	localparam logic [PLAY_W-1:0] PLAY_RST  = PLAY_W'(250);

	typedef enum logic [1:0] {
		ALU_HOLD,
		ALU_LOAD,
		ALU_DIV,
		ALU_MUL
	} alu_op_t;

	typedef struct packed {
		alu_op_t           op;
		logic [SR_W-1:0]   sr_init;
		logic [ACC_W-1:0]  operand;
	} alu_cmd_t;

	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic [SR_W-1:0]  sr;
	} alu_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_AVG,
		ST_HOLD,
		ST_VDIV,
		ST_SQ_LOAD,
		ST_SQ_MUL,
		ST_LIN_LOAD,
		ST_LIN_MUL,
		ST_PROD_LOAD,
		ST_PROD_MUL,
		ST_FREQ
	} state_t;

endpackage
`default_nettype wire

/* sv/fst_if.sv */
// input and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface fst_in_if;
	logic       valid;
	logic       ready;
	logic [9:0] flex_sample;
	logic [9:0] piezo_sample;

	modport source (output valid, output flex_sample, output piezo_sample, input ready);
	modport sink (input valid, input flex_sample, input piezo_sample, output ready);
endinterface

interface fst_out_if;
	logic       valid;
	logic       ready;
	logic [9:0] held_level;
	logic [9:0] tone_frequency_now;
	logic       tone_active;
	logic [9:0] tone_frequency_set;

	modport source (output valid, output held_level, output tone_frequency_now,
		output tone_active, output tone_frequency_set, input ready);
	modport sink (input valid, input held_level, input tone_frequency_now,
		input tone_active, input tone_frequency_set, output ready);
endinterface
`default_nettype wire

/* sv/flex_sensor_tone_conditioner.sv */
// top level: moving average deadband, angle polynomial and tap-driven tone control
//
//  channel   | dir | payload                                              | transfer
//  samples   | in  | flex_sample, piezo_sample                            | valid & ready
//  results   | out | held_level, tone_frequency_now, tone_active,         | valid & ready
//            |     | tone_frequency_set                                   |
//  apb       | in  | paddr, pwdata -> noise/piezo threshold, play time    | psel&penable&pwrite
//
// one item occupies the block until the bit-serial unit has run all of its steps: window
// average division over SUM_W = 10 + clog2(WINDOW_DEPTH) bits, level scaling division
// and three 20-step multiplies, one bit per cycle; no new sample is taken until then.
// reset clears the window by a wrapped flag; no clearing pass is needed.
// a finished result waits in the output register while the next item is taken;
// the block stalls at its last step only if that register is still full.
`timescale 1ns / 1ps
`default_nettype none
module flex_sensor_tone_conditioner
	import fst_pkg::*;
#(
	parameter int WINDOW_DEPTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	fst_in_if.sink                 samples,
	fst_out_if.source              results,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready
);
	localparam int PTR_W = $clog2(WINDOW_DEPTH);
	localparam int SUM_W = LVL_W + $clog2(WINDOW_DEPTH);

	state_t st_q, st_next;

	logic [THR_W-1:0]   noise_q;
	logic [THR_W-1:0]   piezo_thr_q;
	logic [PLAY_W-1:0]  play_q;

	logic [PTR_W-1:0]   ptr_q;
	logic               wrapped_q;
	logic [SUM_W-1:0]   sum_q;
	logic [LVL_W-1:0]   level_q;
	logic [TIMER_W-1:0] timer_q;
	logic               tone_q;
	logic [FREQ_W-1:0]  latched_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [LVL_W-1:0]   flex_q;
	logic [LVL_W-1:0]   piezo_q;
	logic [V_W-1:0]     v_q;
	logic [VSQ_W-1:0]   vsq_q;
	logic [LIN_W-1:0]   lin_q;

	logic               out_valid_q;
	logic [LVL_W-1:0]   out_level_q;
	logic [FREQ_W-1:0]  out_freq_q;
	logic               out_tone_q;
	logic [FREQ_W-1:0]  out_set_q;

	logic [LVL_W-1:0]   ram_rdata;
	logic               ram_we;
	alu_cmd_t           alu_cmd;
	alu_res_t           alu_res;

	logic [LVL_W-1:0]   old_sample;
	logic [SUM_W-1:0]   new_sum;
	logic [LVL_W-1:0]   avg;
	logic [LVL_W-1:0]   diff;
	logic [LVL_W-1:0]   new_level;
	logic [PROD_W-1:0]  prod16;
	logic [ANGLE_W-1:0] angle;
	logic               angle_pos;
	logic [SCALED_W-1:0] scaled;
	logic [15:0]        freq_raw;
	logic [FREQ_W-1:0]  freq_now;
	logic               tap;
	logic [TIMER_W-1:0] timer_base;
	logic               out_free;
	logic               finish;
	logic               cfg_wr;

	fst_ram #(
		.WIDTH(LVL_W),
		.DEPTH(WINDOW_DEPTH)
	) u_window (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ptr_q),
		.wdata(flex_q),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	fst_serial_alu u_alu (
		.clk(clk),
		.cmd(alu_cmd),
		.res(alu_res)
	);

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q     <= NOISE_RST;
			piezo_thr_q <= PIEZO_RST;
			play_q      <= PLAY_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_NOISE: noise_q     <= pwdata[THR_W-1:0];
				REG_PIEZO: piezo_thr_q <= pwdata[THR_W-1:0];
				REG_PLAY:  play_q      <= pwdata[PLAY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_NOISE: prdata = DATA_W'(noise_q);
			REG_PIEZO: prdata = DATA_W'(piezo_thr_q);
			REG_PLAY:  prdata = DATA_W'(play_q);
			default:   prdata = '0;
		endcase
	end

	// datapath
	assign old_sample = wrapped_q ? ram_rdata : '0;
	assign new_sum    = sum_q - SUM_W'(old_sample) + SUM_W'(flex_q);
	assign avg        = alu_res.sr[LVL_W-1:0];
	assign diff       = (avg >= level_q) ? avg - level_q : level_q - avg;
	assign new_level  = (diff >= noise_q) ? avg : level_q;
	assign prod16     = {alu_res.acc, alu_res.sr[SR_W-1 -: PROD_LOW]};
	assign angle      = COEF_CONST + ANGLE_W'(lin_q) - ANGLE_W'(prod16[SQ_W-1:0]);
	assign angle_pos  = !angle[ANGLE_W-1] && (angle != '0);
	assign scaled     = SCALED_W'(angle[ANGLE_W-2:0]) * FREQ_SCALE;
	assign freq_raw   = scaled[SCALED_W-1:FRAC_W];
	assign freq_now   = !angle_pos ? '0 :
		(freq_raw > 16'(FREQ_MAX)) ? FREQ_MAX : freq_raw[FREQ_W-1:0];
	assign tap        = piezo_q > piezo_thr_q;
	assign timer_base = tap ? '0 : timer_q;
	assign out_free   = !out_valid_q || results.ready;
	assign finish     = (st_q == ST_FREQ) && out_free;

	// next state
	always_comb begin
		st_next = st_q;
		unique case (st_q)
			ST_IDLE:      if (samples.valid) st_next = ST_SUM;
			ST_SUM:       st_next = ST_AVG;
			ST_AVG:       if (cnt_q == CNT_W'(1)) st_next = ST_HOLD;
			ST_HOLD:      st_next = ST_VDIV;
			ST_VDIV:      if (cnt_q == CNT_W'(1)) st_next = ST_SQ_LOAD;
			ST_SQ_LOAD:   st_next = ST_SQ_MUL;
			ST_SQ_MUL:    if (cnt_q == CNT_W'(1)) st_next = ST_LIN_LOAD;
			ST_LIN_LOAD:  st_next = ST_LIN_MUL;
			ST_LIN_MUL:   if (cnt_q == CNT_W'(1)) st_next = ST_PROD_LOAD;
			ST_PROD_LOAD: st_next = ST_PROD_MUL;
			ST_PROD_MUL:  if (cnt_q == CNT_W'(1)) st_next = ST_FREQ;
			ST_FREQ:      if (out_free) st_next = ST_IDLE;
			default:      st_next = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		samples.ready   = 1'b0;
		ram_we          = 1'b0;
		alu_cmd.op      = ALU_HOLD;
		alu_cmd.sr_init = '0;
		alu_cmd.operand = '0;
		unique case (st_q)
			ST_IDLE: samples.ready = 1'b1;
			ST_SUM: begin
				ram_we          = 1'b1;
				alu_cmd.op      = ALU_LOAD;
				alu_cmd.sr_init = {new_sum, {(SR_W - SUM_W){1'b0}}};
				alu_cmd.operand = ACC_W'(WINDOW_DEPTH);
			end
			ST_AVG, ST_VDIV: alu_cmd.op = ALU_DIV;
			ST_HOLD: begin
				alu_cmd.op      = ALU_LOAD;
				alu_cmd.sr_init = {new_level, {V_SHIFT{1'b0}}};
				alu_cmd.operand = V_DIVISOR;
			end
			ST_SQ_LOAD: begin
				alu_cmd.op      = ALU_LOAD;
				alu_cmd.sr_init = SR_W'(alu_res.sr[V_W-1:0]);
				alu_cmd.operand = ACC_W'(alu_res.sr[V_W-1:0]);
			end
			ST_LIN_LOAD: begin
				alu_cmd.op      = ALU_LOAD;
				alu_cmd.sr_init = SR_W'(v_q);
				alu_cmd.operand = COEF_LIN;
			end
			ST_PROD_LOAD: begin
				alu_cmd.op      = ALU_LOAD;
				alu_cmd.sr_init = SR_W'(vsq_q);
				alu_cmd.operand = COEF_SQ;
			end
			ST_SQ_MUL, ST_LIN_MUL, ST_PROD_MUL: alu_cmd.op = ALU_MUL;
			ST_FREQ: begin
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ptr_q       <= '0;
			wrapped_q   <= 1'b0;
			sum_q       <= '0;
			level_q     <= '0;
			timer_q     <= '0;
			tone_q      <= 1'b0;
			latched_q   <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_next;
			unique case (st_q)
				ST_SUM: begin
					sum_q <= new_sum;
					cnt_q <= CNT_W'(SUM_W);
					if (ptr_q == PTR_W'(WINDOW_DEPTH - 1)) begin
						ptr_q     <= '0;
						wrapped_q <= 1'b1;
					end else begin
						ptr_q <= ptr_q + PTR_W'(1);
					end
				end
				ST_HOLD: begin
					level_q <= new_level;
					cnt_q   <= CNT_W'(SR_W);
				end
				ST_SQ_LOAD, ST_LIN_LOAD, ST_PROD_LOAD: cnt_q <= CNT_W'(MUL_STEPS);
				ST_AVG, ST_VDIV, ST_SQ_MUL, ST_LIN_MUL, ST_PROD_MUL: cnt_q <= cnt_q - CNT_W'(1);
				ST_IDLE, ST_FREQ: begin
				end
				default: begin
				end
			endcase
			if (finish) begin
				if (tap) begin
					tone_q    <= 1'b1;
					latched_q <= freq_now;
				end else if (timer_q > TIMER_W'(play_q)) begin
					tone_q <= 1'b0;
				end
				if (timer_base != TIMER_MAX) begin
					timer_q <= timer_base + TIMER_W'(1);
				end else begin
					timer_q <= timer_base;
				end
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			flex_q  <= samples.flex_sample;
			piezo_q <= samples.piezo_sample;
		end
		if (st_q == ST_SQ_LOAD) begin
			v_q <= alu_res.sr[V_W-1:0];
		end
		if (st_q == ST_LIN_LOAD) begin
			vsq_q <= prod16[VSQ_W-1:0];
		end
		if (st_q == ST_PROD_LOAD) begin
			lin_q <= prod16[LIN_W-1:0];
		end
		if (finish) begin
			out_level_q <= level_q;
			out_freq_q  <= freq_now;
			out_tone_q  <= tap || !(timer_q > TIMER_W'(play_q)) ? (tap || tone_q) : 1'b0;
			out_set_q   <= tap ? freq_now : latched_q;
		end
	end

	assign results.valid              = out_valid_q;
	assign results.held_level         = out_level_q;
	assign results.tone_frequency_now = out_freq_q;
	assign results.tone_active        = out_tone_q;
	assign results.tone_frequency_set = out_set_q;

	// checks
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_AVG || st_q == ST_VDIV || st_q == ST_SQ_MUL ||
		 st_q == ST_LIN_MUL || st_q == ST_PROD_MUL) |-> cnt_q != '0)
		else $error("serial step counter ran out inside a step state");

	a_wrap_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		wrapped_q |=> wrapped_q)
		else $error("window wrapped flag dropped");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PTR_W'(WINDOW_DEPTH - 1))
		else $error("window pointer beyond depth");

	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_valid_q && st_q == ST_IDLE)
		else $error("finished item did not reach the output register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FREQ && out_valid_q && !results.ready) |=> st_q == ST_FREQ)
		else $error("output register overwritten before transfer");
endmodule
`default_nettype wire

/* sv/fst_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module fst_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* sv/fst_serial_alu.sv */
// bit-serial shift-add multiplier and restoring divider
`timescale 1ns / 1ps
`default_nettype none
module fst_serial_alu
	import fst_pkg::*;
(
	input  wire logic     clk,
	input  wire alu_cmd_t cmd,
	output alu_res_t      res
);
	logic [ACC_W-1:0] acc_q;
	logic [SR_W-1:0]  sr_q;
	logic [ACC_W-1:0] opnd_q;

	logic [REM_W:0]   rem_sh;
	logic [REM_W:0]   rem_sub;
	logic             rem_ge;
	logic [ACC_W:0]   mul_sum;

	// division: shift one dividend bit into the remainder
	assign rem_sh  = {acc_q[REM_W-1:0], sr_q[SR_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, opnd_q[REM_W-1:0]};
	assign rem_sub = rem_ge ? rem_sh - {1'b0, opnd_q[REM_W-1:0]} : rem_sh;

	// multiplication: lsb first, product shifts right into sr
	assign mul_sum = {1'b0, acc_q} + (sr_q[0] ? {1'b0, opnd_q} : '0);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ALU_HOLD: begin
			end
			ALU_LOAD: begin
				acc_q  <= '0;
				sr_q   <= cmd.sr_init;
				opnd_q <= cmd.operand;
			end
			ALU_DIV: begin
				acc_q <= ACC_W'(rem_sub[REM_W-1:0]);
				sr_q  <= {sr_q[SR_W-2:0], rem_ge};
			end
			ALU_MUL: begin
				acc_q <= mul_sum[ACC_W:1];
				sr_q  <= {mul_sum[0], sr_q[SR_W-1:1]};
			end
			default: begin
			end
		endcase
	end

	assign res.acc = acc_q;
	assign res.sr  = sr_q;
endmodule
`default_nettype wire

/* tb/tb_flex_sensor_tone_conditioner.sv */
// self-checking testbench for the flex sensor tone conditioner
`timescale 1ns / 1ps
`default_nettype none
module tb_flex_sensor_tone_conditioner;
	import fst_pkg::*;

	localparam int WIN_DEPTH = 16;
	localparam int SUM_BITS = LVL_W + $clog2(WIN_DEPTH);
	localparam int ITEM_CYCLES = SUM_BITS + 92;
	localparam int LEVEL_TOP = 1023;
	localparam logic [1:0] REG_SPARE = 2'd3;

	localparam longint VOLT_NUM = 2162688;
	localparam longint VOLT_DEN = 10230;
	localparam longint ANGLE_QUAD = 2614886;
	localparam longint ANGLE_LIN = 3624141;
	localparam longint ANGLE_BASE = 4672717;
	localparam longint HZ_PER_DEG = 980 / 90;
	localparam longint HZ_TOP = 1023;
	localparam logic [TIMER_W-1:0] TIMER_TOP = '1;

	typedef struct packed {
		logic [LVL_W-1:0]  held_level;
		logic [FREQ_W-1:0] freq_now;
		logic              tone_active;
		logic [FREQ_W-1:0] freq_set;
	} tone_result_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	fst_in_if  samples_if();
	fst_out_if results_if();

	flex_sensor_tone_conditioner #(.WINDOW_DEPTH(WIN_DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.results(results_if),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// predictor state
	logic [LVL_W-1:0]    flex_window [WIN_DEPTH];
	logic [3:0]          window_slot;
	logic [SUM_BITS-1:0] window_total;
	logic [LVL_W-1:0]    level_now;
	logic [TIMER_W-1:0]  tap_timer;
	logic                tone_on;
	logic [FREQ_W-1:0]   tap_freq;
	logic [THR_W-1:0]    cfg_noise;
	logic [THR_W-1:0]    cfg_piezo;
	logic [PLAY_W-1:0]   cfg_play;

	tone_result_t expected_tones[$];
	int fault_count;
	int burst_left;
	bit gaps_on;
	int rx_hold_req;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [FREQ_W-1:0] level_to_hz(input logic [LVL_W-1:0] lvl);
		longint volts;
		longint volts_sq;
		longint lin_term;
		longint quad_term;
		longint angle;
		longint hz;
		volts = (longint'(lvl) * VOLT_NUM) / VOLT_DEN;
		volts_sq = (volts * volts) >>> 16;
		lin_term = (ANGLE_LIN * volts) >>> 16;
		quad_term = (ANGLE_QUAD * volts_sq) >>> 16;
		angle = ANGLE_BASE + lin_term - quad_term;
		if (angle <= 0)
			return '0;
		hz = (angle * HZ_PER_DEG) >>> 16;
		if (hz > HZ_TOP)
			hz = HZ_TOP;
		return hz[FREQ_W-1:0];
	endfunction

	task automatic advance_conditioner(input logic [LVL_W-1:0] flex, input logic [LVL_W-1:0] piezo,
		output tone_result_t res);
		logic [LVL_W-1:0] avg;
		logic [LVL_W-1:0] avg_gap;
		logic [FREQ_W-1:0] hz;
		window_total = window_total - flex_window[window_slot] + flex;
		flex_window[window_slot] = flex;
		window_slot = window_slot + 1'b1;
		avg = window_total[SUM_BITS-1:SUM_BITS-LVL_W];
		avg_gap = (avg >= level_now) ? avg - level_now : level_now - avg;
		if (avg_gap >= cfg_noise)
			level_now = avg;
		hz = level_to_hz(level_now);
		if (piezo > cfg_piezo) begin
			tone_on = 1'b1;
			tap_freq = hz;
			tap_timer = '0;
		end else if (tap_timer > cfg_play) begin
			tone_on = 1'b0;
		end
		if (tap_timer < TIMER_TOP)
			tap_timer = tap_timer + 1'b1;
		res.held_level = level_now;
		res.freq_now = hz;
		res.tone_active = tone_on;
		res.freq_set = tap_freq;
	endtask

	task automatic note_mismatch(input string what, input int unsigned want, input int unsigned got);
		fault_count++;
		if (fault_count <= 10)
			$display("mismatch %s: expected %0d, got %0d", what, want, got);
	endtask

	// result checker
	always @(posedge clk) begin
		tone_result_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (expected_tones.size() == 0) begin
				note_mismatch("unexpected result, pending", 0, 1);
			end else begin
				want = expected_tones.pop_front();
				if (results_if.held_level !== want.held_level)
					note_mismatch("held_level", want.held_level, results_if.held_level);
				if (results_if.tone_frequency_now !== want.freq_now)
					note_mismatch("tone_frequency_now", want.freq_now,
						results_if.tone_frequency_now);
				if (results_if.tone_active !== want.tone_active)
					note_mismatch("tone_active", want.tone_active, results_if.tone_active);
				if (results_if.tone_frequency_set !== want.freq_set)
					note_mismatch("tone_frequency_set", want.freq_set,
						results_if.tone_frequency_set);
			end
		end
	end

	// receiver stall pattern
	initial begin
		int hold_left;
		int mode_left;
		int mode;
		hold_left = 0;
		mode_left = 0;
		mode = 0;
		results_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req > 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				results_if.ready <= 1'b0;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 4);
					mode_left = $urandom_range(20, 300);
				end
				mode_left--;
				case (mode)
					0: results_if.ready <= 1'b1;
					1: results_if.ready <= ($urandom_range(0, 3) != 0);
					2: results_if.ready <= 1'($urandom_range(0, 1));
					3: results_if.ready <= ($urandom_range(0, 7) == 0);
					default: results_if.ready <= ((mode_left % 64) < 32);
				endcase
			end
		end
	end

	task automatic send_sample(input logic [LVL_W-1:0] flex, input logic [LVL_W-1:0] piezo);
		tone_result_t want;
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 40) : $urandom_range(0, 4);
			if (gap > 0) begin
				samples_if.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
		end
		if (burst_left > 0)
			burst_left--;
		samples_if.valid <= 1'b1;
		samples_if.flex_sample <= flex;
		samples_if.piezo_sample <= piezo;
		@(posedge clk);
		while (!samples_if.ready)
			@(posedge clk);
		advance_conditioner(flex, piezo, want);
		expected_tones.push_back(want);
		@(negedge clk);
	endtask

	task automatic drain_results();
		samples_if.valid <= 1'b0;
		while (expected_tones.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_NOISE: cfg_noise = data[THR_W-1:0];
			REG_PIEZO: cfg_piezo = data[THR_W-1:0];
			REG_PLAY:  cfg_play = data[PLAY_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_registers();
		logic [1:0] idx;
		logic [DATA_W-1:0] want;
		logic [DATA_W-1:0] got;
		for (int i = 0; i < 3; i++) begin
			idx = i[1:0];
			case (idx)
				REG_NOISE: want = DATA_W'(cfg_noise);
				REG_PIEZO: want = DATA_W'(cfg_piezo);
				default:   want = DATA_W'(cfg_play);
			endcase
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= {idx, 2'b00};
			@(negedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready)
				@(posedge clk);
			got = prdata;
			@(negedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
			@(negedge clk);
			if (got !== want)
				note_mismatch("register read", want, got);
		end
	endtask

	task automatic set_config(input logic [THR_W-1:0] noise, input logic [THR_W-1:0] piezo,
		input logic [PLAY_W-1:0] play);
		logic [DATA_W-1:0] data;
		drain_results();
		data = $urandom();
		data[THR_W-1:0] = noise;
		write_reg(REG_NOISE, data);
		data = $urandom();
		data[THR_W-1:0] = piezo;
		write_reg(REG_PIEZO, data);
		data = $urandom();
		data[PLAY_W-1:0] = play;
		write_reg(REG_PLAY, data);
		check_registers();
	endtask

	task automatic test_window_extremes();
		for (int i = 0; i < WIN_DEPTH; i++) begin
			case (i)
				0: send_sample(10'd1023, 10'd150);
				1: send_sample(10'd1023, 10'd151);
				2: send_sample(10'd1023, 10'd1023);
				default: send_sample(10'd1023, 10'd0);
			endcase
		end
		for (int i = 0; i < 8; i++)
			send_sample(10'd0, (i % 2) ? 10'd1023 : 10'd0);
	endtask

	task automatic test_register_access();
		drain_results();
		check_registers();
		write_reg(REG_NOISE, 32'hFFFF_FC00);
		write_reg(REG_PIEZO, 32'h0000_0000);
		write_reg(REG_PLAY, 32'hFFFF_0000);
		write_reg(REG_SPARE, 32'hFFFF_FFFF);
		check_registers();
		for (int i = 0; i < 10; i++)
			send_sample(10'($urandom_range(0, LEVEL_TOP)), (i % 3 == 0) ? 10'd1 : 10'd0);
	endtask

	task automatic test_deadband_sweep();
		int flex_mode;
		int run_left;
		int flex_val;
		int flex_step;
		int pick;
		logic [LVL_W-1:0] flex;
		logic [LVL_W-1:0] piezo;
		logic [THR_W-1:0] noise;
		logic [THR_W-1:0] piezo_thr;
		logic [PLAY_W-1:0] play;
		run_left = 0;
		flex_val = 0;
		flex_step = 1;
		flex_mode = 0;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					noise = '0;
					piezo_thr = '0;
					play = '0;
				end
				1: begin
					noise = '1;
					piezo_thr = '1;
					play = '1;
				end
				2: begin
					noise = NOISE_RST;
					piezo_thr = PIEZO_RST;
					play = 16'd12;
				end
				default: begin
					noise = ($urandom_range(0, 3) == 0) ? THR_W'($urandom_range(0, LEVEL_TOP))
						: THR_W'($urandom_range(0, 40));
					piezo_thr = THR_W'($urandom_range(0, LEVEL_TOP));
					play = ($urandom_range(0, 3) == 0) ? PLAY_W'($urandom_range(0, 65535))
						: PLAY_W'($urandom_range(0, 40));
				end
			endcase
			set_config(noise, piezo_thr, play);
			for (int n = 0; n < 95; n++) begin
				if (run_left == 0) begin
					flex_mode = $urandom_range(0, 5);
					run_left = $urandom_range(4, 24);
					flex_val = $urandom_range(0, LEVEL_TOP);
					flex_step = $urandom_range(1, 64);
					if ($urandom_range(0, 1))
						flex_step = -flex_step;
				end
				run_left--;
				if (flex_mode < 3) begin
					flex_val = flex_val + $urandom_range(0, 4) - 2;
				end else if (flex_mode < 5) begin
					flex_val = flex_val + flex_step;
				end else begin
					flex_val = $urandom_range(0, LEVEL_TOP);
				end
				if (flex_val < 0)
					flex_val = 0;
				if (flex_val > LEVEL_TOP)
					flex_val = LEVEL_TOP;
				flex = flex_val[LVL_W-1:0];
				pick = $urandom_range(0, 15);
				if (pick < 3 && cfg_piezo != '1)
					piezo = LVL_W'($urandom_range(int'(cfg_piezo) + 1, LEVEL_TOP));
				else if (pick < 6)
					piezo = LVL_W'($urandom_range(0, LEVEL_TOP));
				else
					piezo = LVL_W'($urandom_range(0, int'(cfg_piezo)));
				send_sample(flex, piezo);
			end
		end
	endtask

	task automatic test_output_backpressure();
		set_config(10'd4, 10'd500, 16'd6);
		gaps_on = 1'b0;
		rx_hold_req = 8 * ITEM_CYCLES;
		for (int i = 0; i < 40; i++)
			send_sample(10'($urandom_range(0, LEVEL_TOP)), 10'($urandom_range(0, LEVEL_TOP)));
		gaps_on = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		samples_if.valid = 1'b0;
		samples_if.flex_sample = '0;
		samples_if.piezo_sample = '0;
		foreach (flex_window[i])
			flex_window[i] = '0;
		window_slot = '0;
		window_total = '0;
		level_now = '0;
		tap_timer = '0;
		tone_on = 1'b0;
		tap_freq = '0;
		cfg_noise = NOISE_RST;
		cfg_piezo = PIEZO_RST;
		cfg_play = PLAY_RST;
		fault_count = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		rx_hold_req = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_window_extremes();
		test_register_access();
		test_deadband_sweep();
		test_output_backpressure();

		drain_results();
		repeat (ITEM_CYCLES + 50) @(negedge clk);
		if (fault_count == 0 && expected_tones.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
sv/fst_pkg.sv
sv/fst_if.sv
sv/fst_ram.sv
sv/fst_serial_alu.sv
sv/flex_sensor_tone_conditioner.sv
tb/tb_flex_sensor_tone_conditioner.sv
